### sv/sssd_pkg.sv
package sssd_pkg;

    // Operation codes carried in the op field of a command transaction.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int VALUE_W = 16;
    localparam int WORD_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int THOU_W  = 7;   // value / 1000 is at most 65
    localparam int REM3_W  = 10;  // remainder below 1000
    localparam int REM2_W  = 7;   // remainder below 100

    // value / 1000 == (value * THOU_RECIP) >> THOU_SHIFT for every 16-bit value.
    localparam int THOU_SHIFT = 26;
    localparam logic [16:0] THOU_RECIP = 17'd67109;
    localparam logic [VALUE_W-1:0] THOUSAND = 16'd1000;

    localparam logic [WORD_W-1:0] BLANK_WORD = 16'hA09E;
    localparam logic [WORD_W-1:0] LED_BITS   = 16'h000E;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] port_word;
        logic              last_of_run;
    } word_t;

    // Segment pattern of one decimal digit on the expander pins.
    function automatic logic [WORD_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [WORD_W-1:0] p;
        case (d)
            4'd0:    p = 16'h4B60;
            4'd1:    p = 16'h4800;
            4'd2:    p = 16'h5340;
            4'd3:    p = 16'h5A40;
            4'd4:    p = 16'h5820;
            4'd5:    p = 16'h1A60;
            4'd6:    p = 16'h1B60;
            4'd7:    p = 16'h4840;
            4'd8:    p = 16'h5B60;
            4'd9:    p = 16'h5A60;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

    // Full port word for a digit at a given position: segments, the one
    // active-low cathode, and the indicator LEDs on all but the last digit.
    function automatic logic [WORD_W-1:0] digit_word(input logic [1:0] pos,
                                                     input logic [DIGIT_W-1:0] d);
        logic [WORD_W-1:0] w;
        case (pos)
            2'd0:    w = 16'hA010 | LED_BITS;
            2'd1:    w = 16'hA080 | LED_BITS;
            2'd2:    w = 16'h2090 | LED_BITS;
            default: w = 16'h8090;
        endcase
        return w | seg_pattern(d);
    endfunction

    // Quotient by ten of a value below 100, from nine parallel compares.
    function automatic logic [DIGIT_W-1:0] div_by_ten(input logic [REM2_W-1:0] x);
        logic [DIGIT_W-1:0] q;
        q = '0;
        for (int k = 1; k < 10; k++) begin
            if (x >= REM2_W'(k * 10)) begin
                q = DIGIT_W'(k);
            end
        end
        return q;
    endfunction

    // Quotient by one hundred of a value below 1000.
    function automatic logic [DIGIT_W-1:0] div_by_hundred(input logic [REM3_W-1:0] x);
        logic [DIGIT_W-1:0] q;
        q = '0;
        for (int k = 1; k < 10; k++) begin
            if (x >= REM3_W'(k * 100)) begin
                q = DIGIT_W'(k);
            end
        end
        return q;
    endfunction

endpackage

### sv/seven_segment_scan_driver_core.sv
// Channel   Signals                          Payload type       Role
// -------   ------------------------------   ----------------   ---------------------------
// command   cmd_valid / cmd_ready / cmd_data sssd_pkg::cmd_t    load a value or scan tick
// word      word_valid/word_ready/word_data  sssd_pkg::word_t   expander words, two per tick
//
// A command transaction passes four register stages. A load retires on
// reaching the last stage; a tick stays there until the single output
// register, at one word per cycle while word_ready allows, has taken both
// of its words. Loads can be accepted on every cycle while no tick ahead
// is held; a run of ticks goes slower, as each holds the last stage for
// both words. The asynchronous reset clears the pipeline, the scan
// position and the four stored digit words. A low word_ready holds the
// output word and backs up the stages behind it, which then drops cmd_ready.
module seven_segment_scan_driver_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  sssd_pkg::cmd_t  cmd_data,
    output logic            word_valid,
    input  logic            word_ready,
    output sssd_pkg::word_t word_data
);

    // Stage 1: the accepted command.
    logic                               s1_valid_reg;
    logic                               s1_op_reg;
    logic [sssd_pkg::VALUE_W-1:0]       s1_value_reg;

    // Stage 2: the thousands quotient, found by a reciprocal multiply.
    logic                               s2_valid_reg;
    logic                               s2_op_reg;
    logic [sssd_pkg::VALUE_W-1:0]       s2_value_reg;
    logic [sssd_pkg::THOU_W-1:0]        s2_thou_reg;

    // Stage 3: the thousands digit and the remainder below 1000.
    logic                               s3_valid_reg;
    logic                               s3_op_reg;
    logic [sssd_pkg::DIGIT_W-1:0]       s3_d0_reg;
    logic [sssd_pkg::REM3_W-1:0]        s3_rem_reg;

    // Stage 4: the hundreds digit and the remainder below 100. The tens and
    // units digits are split off here and the item is retired.
    logic                               s4_valid_reg;
    logic                               s4_op_reg;
    logic [sssd_pkg::DIGIT_W-1:0]       s4_d0_reg;
    logic [sssd_pkg::DIGIT_W-1:0]       s4_d1_reg;
    logic [sssd_pkg::REM2_W-1:0]        s4_rem_reg;

    // A tick in stage 4 first sends the blanking word (phase low), then the
    // digit word (phase high).
    logic                               phase_reg;
    logic                               phase_next;
    logic [1:0]                         scan_pos_reg;
    logic [1:0]                         scan_pos_next;
    logic [sssd_pkg::WORD_W-1:0]        digit_words_reg [4];

    logic                               word_valid_reg;
    sssd_pkg::word_t                    word_data_reg;
    sssd_pkg::word_t                    word_data_next;

    logic word_free;
    logic s4_is_tick;
    logic emit;
    logic s4_done;
    logic s4_open;
    logic s3_open;
    logic s2_open;
    logic s1_open;

    // Datapath intermediates.
    logic [32:0]                        thou_prod;
    logic [sssd_pkg::THOU_W-1:0]        thou_next;
    logic [sssd_pkg::VALUE_W-1:0]       thou_scaled;
    logic [sssd_pkg::VALUE_W-1:0]       rem3_full;
    logic [sssd_pkg::DIGIT_W-1:0]       thou_tens;
    logic [sssd_pkg::REM2_W-1:0]        thou_mod;
    logic [sssd_pkg::DIGIT_W-1:0]       hund_q;
    logic [sssd_pkg::REM3_W-1:0]        hund_scaled;
    logic [sssd_pkg::REM3_W-1:0]        rem2_full;
    logic [sssd_pkg::DIGIT_W-1:0]       tens_q;
    logic [sssd_pkg::REM2_W-1:0]        units_full;

    // Pipeline flow control. Every stage moves when the one after it is
    // empty or moving on; stage 4 moves when its item is finished.
    assign word_free  = !word_valid_reg || word_ready;
    assign s4_is_tick = s4_valid_reg && (s4_op_reg == sssd_pkg::OP_TICK);
    assign emit       = s4_is_tick && word_free;
    assign s4_done    = s4_valid_reg && ((s4_op_reg == sssd_pkg::OP_LOAD) ||
                                         (phase_reg && word_free));
    assign s4_open    = !s4_valid_reg || s4_done;
    assign s3_open    = !s3_valid_reg || s4_open;
    assign s2_open    = !s2_valid_reg || s3_open;
    assign s1_open    = !s1_valid_reg || s2_open;
    assign cmd_ready  = s1_open;

    // Digit split. The value wraps modulo 10000 because the thousands
    // quotient is reduced modulo 10 in stage 3.
    always_comb
    begin
        thou_prod   = 33'(s1_value_reg) * 33'(sssd_pkg::THOU_RECIP);
        thou_next   = thou_prod[sssd_pkg::THOU_SHIFT +: sssd_pkg::THOU_W];

        thou_scaled = sssd_pkg::VALUE_W'(s2_thou_reg) * sssd_pkg::THOUSAND;
        rem3_full   = s2_value_reg - thou_scaled;
        thou_tens   = sssd_pkg::div_by_ten(s2_thou_reg);
        thou_mod    = s2_thou_reg - (sssd_pkg::REM2_W'(thou_tens) * 7'd10);

        hund_q      = sssd_pkg::div_by_hundred(s3_rem_reg);
        hund_scaled = sssd_pkg::REM3_W'(hund_q) * 10'd100;
        rem2_full   = s3_rem_reg - hund_scaled;

        tens_q      = sssd_pkg::div_by_ten(s4_rem_reg);
        units_full  = s4_rem_reg - (sssd_pkg::REM2_W'(tens_q) * 7'd10);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        scan_pos_next = scan_pos_reg;
        if (emit)
        begin
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                scan_pos_next = scan_pos_reg + 2'd1;
            end
        end
        if (phase_reg)
        begin
            word_data_next.port_word   = digit_words_reg[scan_pos_reg];
            word_data_next.last_of_run = 1'b1;
        end
        else
        begin
            word_data_next.port_word   = sssd_pkg::BLANK_WORD;
            word_data_next.last_of_run = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            scan_pos_reg   <= 2'd0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_open)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_open)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_open)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            phase_reg    <= phase_next;
            scan_pos_reg <= scan_pos_next;
            if (emit)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (word_ready)
            begin
                word_valid_reg <= 1'b0;
            end
        end
    end

    // Stored digit words have a defined reset value, so they are cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                digit_words_reg[k] <= '0;
            end
        end
        else if (s4_valid_reg && (s4_op_reg == sssd_pkg::OP_LOAD))
        begin
            digit_words_reg[0] <= sssd_pkg::digit_word(2'd0, s4_d0_reg);
            digit_words_reg[1] <= sssd_pkg::digit_word(2'd1, s4_d1_reg);
            digit_words_reg[2] <= sssd_pkg::digit_word(2'd2, tens_q);
            digit_words_reg[3] <= sssd_pkg::digit_word(2'd3,
                                                       units_full[sssd_pkg::DIGIT_W-1:0]);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_open && cmd_valid)
        begin
            s1_op_reg    <= cmd_data.op;
            s1_value_reg <= cmd_data.value;
        end
        if (s2_open && s1_valid_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_value_reg <= s1_value_reg;
            s2_thou_reg  <= thou_next;
        end
        if (s3_open && s2_valid_reg)
        begin
            s3_op_reg  <= s2_op_reg;
            s3_d0_reg  <= thou_mod[sssd_pkg::DIGIT_W-1:0];
            s3_rem_reg <= rem3_full[sssd_pkg::REM3_W-1:0];
        end
        if (s4_open && s3_valid_reg)
        begin
            s4_op_reg  <= s3_op_reg;
            s4_d0_reg  <= s3_d0_reg;
            s4_d1_reg  <= hund_q;
            s4_rem_reg <= rem2_full[sssd_pkg::REM2_W-1:0];
        end
        if (emit)
        begin
            word_data_reg <= word_data_next;
        end
    end

    assign word_valid = word_valid_reg;
    assign word_data  = word_data_reg;

    // The second half of a tick is only ever pending for a tick in stage 4.
    a_phase_tick: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (s4_valid_reg && (s4_op_reg == sssd_pkg::OP_TICK)))
        else $error("digit phase set without a tick in the last stage");

    // A waiting blanking word always has its digit word still owed.
    a_blank_owes_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid_reg && !word_data_reg.last_of_run) |-> phase_reg)
        else $error("blanking word pending but no digit word owed");

    // A waiting digit word closes its tick; no half tick is left behind it.
    a_digit_closes_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid_reg && word_data_reg.last_of_run) |-> !phase_reg)
        else $error("digit word pending while a tick is half done");

    // The scan position moves only when a digit word is produced.
    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_pos_reg != $past(scan_pos_reg)) |->
            ($past(emit) && $past(phase_reg) && word_valid_reg && word_data_reg.last_of_run))
        else $error("scan position moved without a digit word");

endmodule
